>>> src/signed_int_to_decimal_ascii_core_macros.svh
// Assertion macros used by the port-level checker of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SITDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sitda: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SITDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sitda: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define SITDA_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sitda: reset check failed");

`endif

>>> src/sitda_pkg.sv
// Types, constants and conversion functions of the decimal text converter.
package sitda_pkg;

  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 7;
  localparam int LEN_W     = 6;
  localparam int DIGIT_W   = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W     = NUM_DIGITS * DIGIT_W;
  localparam int CNT_W     = 4;

  // Shift-and-add-3 conversion split over several pipeline stages.
  localparam int DD_STAGES = 4;
  localparam int DD_BITS   = VALUE_W / DD_STAGES;

  // APB register map.
  localparam int ADDR_W = 3;
  localparam logic REG_MAX_LENGTH = 1'b0;

  localparam logic [CHAR_W-1:0]  CH_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0]  CH_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0]  CH_NUL   = 7'd0;
  localparam logic [VALUE_W-1:0] MIN_VALUE = 32'h8000_0000;
  localparam logic [LEN_W-1:0]   MIN_FULL_LEN = 6'd12;
  localparam logic [LEN_W-1:0]   MAX_LEN_RESET = 6'd32;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  // One conversion stage: BCD accumulator plus the magnitude bits still to shift in.
  typedef struct packed {
    bcd_t               bcd;
    logic [VALUE_W-1:0] rest;
    logic               neg;
    logic               is_min;
  } dd_t;

  // Ready-to-emit request: digits, how many of them to send, and the sign flag.
  typedef struct packed {
    bcd_t             bcd;
    logic [CNT_W-1:0] cnt;
    logic             sign;
  } prep_t;

  function automatic dd_t dd_stage(input dd_t d);
    dd_t                o;
    logic [BCD_W-1:0]   acc;
    o   = d;
    acc = d.bcd;
    for (int j = 0; j < DD_BITS; j++) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        if (acc[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          acc[k*DIGIT_W +: DIGIT_W] = acc[k*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      acc    = {acc[BCD_W-2:0], o.rest[VALUE_W-1]};
      o.rest = {o.rest[VALUE_W-2:0], 1'b0};
    end
    o.bcd = acc;
    return o;
  endfunction

endpackage

>>> src/signed_int_to_decimal_ascii_core.sv
// Top level: pipelined signed 32-bit integer to decimal ASCII character stream.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------
//   value    | value_valid/value_stall | value (32b signed)
//   text     | text_valid/text_stall   | text_char (7b), last (1b)
//   config   | APB psel/penable/...    | max_length at byte address 0
//
// A value passes one magnitude stage, four binary-to-BCD stages and one
// length-trim stage before the serializer loads it. The serializer sends
// one character per cycle while text_stall is low: 1 to 12 characters per
// value (digits, optional minus, terminator); the character port sets the rate.
// Up to six further values queue in the pipeline while one is being sent.
// rst is synchronous and active high; it clears valid bits and max_length=32.
// Stalls propagate stage by stage; a stage holds while its successor is full
// and held.
module signed_int_to_decimal_ascii_core (
  input  logic                           clk,
  input  logic                           rst,
  // value request channel
  input  logic                           value_valid,
  output logic                           value_stall,
  input  logic signed [sitda_pkg::VALUE_W-1:0] value,
  // text request channel
  output logic                           text_valid,
  input  logic                           text_stall,
  output logic [sitda_pkg::CHAR_W-1:0]   text_char,
  output logic                           last,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sitda_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import sitda_pkg::*;

  localparam int NST = DD_STAGES + 2;  // magnitude, BCD stages, trim

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] max_length;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_MAX_LENGTH);
  assign prdata  = reg_sel ? {{(32-LEN_W){1'b0}}, max_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_length <= pwdata[LEN_W-1:0];
    end
  end

  // Characters allowed before the terminator.
  logic [LEN_W-1:0] limit;
  assign limit = (max_length == '0) ? '0 : max_length - 1'b1;

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage may take new data when it is empty or moving on
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;
  logic           ser_load;

  always_comb begin
    rdy[NST-1] = !vld[NST-1] || ser_load;
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign value_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= value_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: sign and magnitude. The most negative value negates to itself,
  // which read as unsigned is the right magnitude.
  // ---------------------------------------------------------------------------
  dd_t st [DD_STAGES+1];

  always_ff @(posedge clk) begin
    if (rdy[0] && value_valid) begin
      st[0].bcd    <= '0;
      st[0].neg    <= value[VALUE_W-1];
      st[0].is_min <= (value == MIN_VALUE);
      st[0].rest   <= value[VALUE_W-1] ? VALUE_W'(-value) : VALUE_W'(value);
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1..DD_STAGES: shift-and-add-3, a slice of magnitude bits each
  // ---------------------------------------------------------------------------
  for (genvar g = 1; g <= DD_STAGES; g++) begin : g_dd
    always_ff @(posedge clk) begin
      if (rdy[g] && vld[g-1]) begin
        st[g] <= dd_stage(st[g-1]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Trim stage: count significant digits, keep the low-order ones that fit,
  // add the sign only if there is room after all digits.
  // ---------------------------------------------------------------------------
  prep_t            prep;
  prep_t            prep_next;
  logic [CNT_W-1:0] lead;

  always_comb begin
    lead = CNT_W'(1);  // zero still prints one digit
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (st[DD_STAGES].bcd[k] != '0) begin
        lead = CNT_W'(k + 1);
      end
    end
    prep_next.bcd  = st[DD_STAGES].bcd;
    prep_next.cnt  = ({{(LEN_W-CNT_W){1'b0}}, lead} < limit) ? lead : limit[CNT_W-1:0];
    prep_next.sign = st[DD_STAGES].neg && ({{(LEN_W-CNT_W){1'b0}}, lead} < limit);
    // Most negative value prints whole or not at all.
    if (st[DD_STAGES].is_min && (max_length < MIN_FULL_LEN)) begin
      prep_next.cnt  = '0;
      prep_next.sign = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1] && vld[NST-2]) begin
      prep <= prep_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Serializer: minus, digits high to low, then the terminator
  // ---------------------------------------------------------------------------
  logic             busy;
  logic             sign_pend;
  logic [CNT_W-1:0] cnt;
  bcd_t             digs;
  logic             emit;
  logic             term_now;
  logic [CNT_W-1:0] dig_idx;

  assign emit     = busy && (!text_valid || !text_stall);
  assign term_now = emit && !sign_pend && (cnt == '0);
  assign ser_load = vld[NST-1] && (!busy || term_now);
  assign dig_idx  = cnt - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      text_valid <= 1'b0;
    end else begin
      // Output register: take a character or drop valid once it is taken.
      if (emit) begin
        text_valid <= 1'b1;
        if (sign_pend) begin
          text_char <= CH_MINUS;
          last      <= 1'b0;
          sign_pend <= 1'b0;
        end else if (cnt != '0) begin
          text_char <= CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digs[dig_idx]};
          last      <= 1'b0;
          cnt       <= dig_idx;
        end else begin
          text_char <= CH_NUL;
          last      <= 1'b1;
        end
      end else if (!text_stall) begin
        text_valid <= 1'b0;
      end
      // Load the next request, or go idle once the terminator is out.
      if (ser_load) begin
        busy      <= 1'b1;
        sign_pend <= prep.sign;
        cnt       <= prep.cnt;
        digs      <= prep.bcd;
      end else if (term_now) begin
        busy      <= 1'b0;
      end
    end
  end

endmodule

>>> src/sitda_checker.sv
// Port-level checker for the decimal text converter, bound to the top level.
`include "signed_int_to_decimal_ascii_core_macros.svh"

module sitda_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         text_valid,
  input logic                         text_stall,
  input logic [sitda_pkg::CHAR_W-1:0] text_char,
  input logic                         last
);
  import sitda_pkg::*;

  // Hold a stalled character.
  `SITDA_ASSERT_NEXT(a_hold, text_valid && text_stall, text_valid && $stable(text_char) && $stable(last))

  // Text characters are digits or a minus sign.
  `SITDA_ASSERT_NOW(a_charset, text_valid && !last, (text_char >= CH_ZERO && text_char <= CH_ZERO + 7'd9) || text_char == CH_MINUS)

  // The terminator is NUL.
  `SITDA_ASSERT_NOW(a_term, text_valid && last, text_char == CH_NUL)

  // Nothing comes out right after reset.
  `SITDA_ASSERT_NEXT_ALWAYS(a_reset, rst, !text_valid)

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (.*);
